/* hw/rtl/threshold_load_balancer_core_assert.svh */
// Assertion macros for the threshold load balancer.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef THRESHOLD_LOAD_BALANCER_CORE_ASSERT_SVH
`define THRESHOLD_LOAD_BALANCER_CORE_ASSERT_SVH
// Implication check, disabled in reset.
`define TLB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check, disabled in reset.
`define TLB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* hw/rtl/tlb_pkg.sv */
// Shared types and constants of the threshold load balancer.
// No dependencies.
package tlb_pkg;
  localparam int NODES       = 8;
  localparam int QUEUE_DEPTH = 8;
  localparam int NODE_W      = $clog2(NODES);
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_W       = NODE_W + QIDX_W;
  localparam logic [15:0] THRESHOLD_RESET = 16'd40;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  // INT_MAX in a 40-bit signed slack
  localparam logic signed [39:0] SLACK_MAX = 40'sh007FFF_FFFF;
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] job_id;
    logic [15:0] burst_len;
    logic [2:0]  node;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] job_start;
    logic        migrated;
    logic [15:0] moved_job_id;
    logic [2:0]  from_node;
    logic [2:0]  to_node;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [31:0] start;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch input word
    logic drop_start;  // reset node pointer for drop sweep
    logic drop_step;   // examine head of current node
    logic append;      // arrival append
    logic scan_start;  // start slack sweep
    logic scan_step;   // one step of the sweep
    logic mig_rd;      // read tail entries of source
    logic mig_do;      // perform migration, advance time
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic drop_done;
    logic scan_done;
  } sts_t;

  function automatic logic [31:0] end_of(entry_t e);
    logic [32:0] s;
    s = {1'b0, e.start} + {17'd0, e.burst};
    return s[32] ? TIME_MAX : s[31:0];
  endfunction
endpackage

/* hw/rtl/tlb_datapath.sv */
// Datapath of the threshold load balancer: job memory, queues, slack sweep.
// Depends on tlb_pkg and threshold_load_balancer_core_assert.svh.
`include "threshold_load_balancer_core_assert.svh"
module tlb_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  tlb_pkg::cmd_t     cmd,
  output tlb_pkg::sts_t     sts,
  input  tlb_pkg::in_word_t in_word,
  input  logic [15:0]       threshold,
  output tlb_pkg::out_word_t res
);
  localparam int NW = tlb_pkg::NODE_W;
  localparam int QW = tlb_pkg::QIDX_W;
  localparam int CW = tlb_pkg::QCNT_W;
  localparam int MEMW = tlb_pkg::MEM_W;

  tlb_pkg::entry_t mem [tlb_pkg::NODES * tlb_pkg::QUEUE_DEPTH];
  tlb_pkg::entry_t rd_r;

  logic [31:0]        now_r;
  logic [QW-1:0]      head_r  [tlb_pkg::NODES];
  logic [CW-1:0]      cnt_r   [tlb_pkg::NODES];
  logic [31:0]        lend_r  [tlb_pkg::NODES];
  logic               used_r  [tlb_pkg::NODES];
  tlb_pkg::in_word_t  word_r;

  // sweep state
  logic [NW:0]        n_r;       // node under walk, one wider to hold NODES
  logic [CW-1:0]      k_r;       // entry within node
  logic               rdv_r;     // rd_r holds entry (n_r,k_r) requested last cycle
  logic signed [39:0] work_r;
  logic signed [39:0] bmax_r, bmin_r;
  logic [NW-1:0]      low_r, high_r;
  logic [CW-1:0]      step_r;    // read sub-step for migration
  tlb_pkg::entry_t    mv_r;
  tlb_pkg::out_word_t res_r;
  tlb_pkg::out_word_t res_nxt;

  logic [NW-1:0] nn;
  logic [NW-1:0] wn;
  logic          in_range;
  logic          acc_ok;
  logic          do_move;
  logic [CW-1:0] ccur;
  logic [31:0]   astart;
  logic [MEMW-1:0] raddr;

  assign nn = n_r[NW-1:0];
  assign ccur = cnt_r[nn];
  assign in_range = ({1'b0, word_r.node} < 4'(tlb_pkg::NODES));
  assign wn = NW'(word_r.node);
  assign acc_ok = in_range && (cnt_r[wn] < CW'(tlb_pkg::QUEUE_DEPTH));
  assign do_move = (cnt_r[high_r] >= CW'(2)) && (high_r != low_r) &&
                   (cnt_r[low_r] < CW'(tlb_pkg::QUEUE_DEPTH));
  assign sts.is_tick = word_r.mode == tlb_pkg::MODE_TICK;
  assign sts.drop_done = (n_r == (NW+1)'(tlb_pkg::NODES));
  assign sts.scan_done = (n_r == (NW+1)'(tlb_pkg::NODES));
  assign res = res_r;

  function automatic logic [QW-1:0] slot(logic [QW-1:0] h, logic [CW-1:0] k);
    logic [CW:0] s;
    s = CW'(h) + k;
    return QW'(s % tlb_pkg::QUEUE_DEPTH);
  endfunction

  // read address: drop walks heads, scan walks entries, migration reads tail/new tail
  always_comb begin
    raddr = {nn, slot(head_r[nn], k_r)};
    if (cmd.drop_step) raddr = {nn, head_r[nn]};
    if (cmd.mig_rd) raddr = {high_r, slot(head_r[high_r], cnt_r[high_r] - CW'(step_r) - CW'(1))};
  end

  logic signed [39:0] slack;
  logic               leave_node;
  always_comb begin
    slack = $signed({24'd0, threshold}) - work_r;
    leave_node = (k_r >= ccur);
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
    if (cmd.append && acc_ok)
      mem[{wn, slot(head_r[wn], cnt_r[wn])}] <= tlb_pkg::entry_t'{word_r.job_id,
        word_r.burst_len, astart};
    if (cmd.mig_do && do_move)
      mem[{low_r, slot(head_r[low_r], cnt_r[low_r])}] <= tlb_pkg::entry_t'{mv_r.id,
        mv_r.burst, astart};
  end

  always_comb begin
    if (cmd.mig_do)
      astart = (used_r[low_r] && lend_r[low_r] > now_r) ? lend_r[low_r] : now_r;
    else
      astart = (used_r[wn] && lend_r[wn] > now_r) ? lend_r[wn] : now_r;
  end

  always_comb begin
    res_nxt = '0;
    if (cmd.append && acc_ok) begin
      res_nxt.accepted  = 1'b1;
      res_nxt.job_start = astart;
    end
    if (cmd.mig_do && do_move) begin
      res_nxt.job_start    = astart;
      res_nxt.migrated     = 1'b1;
      res_nxt.moved_job_id = mv_r.id;
      res_nxt.from_node    = 3'(high_r);
      res_nxt.to_node      = 3'(low_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      for (int i = 0; i < tlb_pkg::NODES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
        lend_r[i] <= '0;
        used_r[i] <= 1'b0;
      end
      n_r <= '0; k_r <= '0; rdv_r <= 1'b0; step_r <= '0;
    end else begin
      if (cmd.take) word_r <= in_word;
      if (cmd.drop_start || cmd.scan_start) begin
        n_r <= '0; k_r <= '0; rdv_r <= 1'b0; work_r <= '0; step_r <= '0;
        bmax_r <= '0; bmin_r <= tlb_pkg::SLACK_MAX; low_r <= '0; high_r <= '0;
      end
      // drop: request head, next cycle test it
      if (cmd.drop_step) begin
        if (!rdv_r) begin
          if (ccur == '0) n_r <= n_r + 1'b1;
          else rdv_r <= 1'b1;
        end else begin
          rdv_r <= 1'b0;
          if (tlb_pkg::end_of(rd_r) < now_r) begin
            head_r[nn] <= slot(head_r[nn], CW'(1));
            cnt_r[nn]  <= ccur - 1'b1;
          end else n_r <= n_r + 1'b1;
        end
      end
      // scan: request an entry, then accumulate it; at the end of a node, score its slack
      if (cmd.scan_step) begin
        if (!rdv_r) begin
          if (leave_node) begin
            if (slack > bmax_r) begin bmax_r <= slack; low_r <= nn; end
            if (ccur != CW'(1) && slack < bmin_r) begin bmin_r <= slack; high_r <= nn; end
            n_r <= n_r + 1'b1; k_r <= '0; work_r <= '0;
          end else rdv_r <= 1'b1;
        end else begin
          rdv_r <= 1'b0;
          k_r <= k_r + 1'b1;
          if (k_r == '0)
            work_r <= work_r + $signed({8'd0, tlb_pkg::end_of(rd_r)}) - $signed({8'd0, now_r});
          else
            work_r <= work_r + $signed({24'd0, rd_r.burst});
        end
      end
      // migration reads: step 0 requests tail, step 1 captures it and requests new tail
      if (cmd.mig_rd) begin
        step_r <= step_r + 1'b1;
      end
      if (step_r == CW'(1) && cmd.mig_rd) mv_r <= rd_r;
      if (cmd.append || cmd.mig_do) res_r <= res_nxt;
      if (cmd.append && acc_ok) begin
        cnt_r[wn]  <= cnt_r[wn] + 1'b1;
        lend_r[wn] <= tlb_pkg::end_of(tlb_pkg::entry_t'{word_r.job_id, word_r.burst_len, astart});
        used_r[wn] <= 1'b1;
      end
      if (cmd.mig_do) begin
        if (do_move) begin
          cnt_r[high_r]  <= cnt_r[high_r] - 1'b1;
          lend_r[high_r] <= tlb_pkg::end_of(rd_r);
          cnt_r[low_r]   <= cnt_r[low_r] + 1'b1;
          lend_r[low_r]  <= tlb_pkg::end_of(tlb_pkg::entry_t'{mv_r.id, mv_r.burst, astart});
          used_r[low_r]  <= 1'b1;
        end
        if (now_r != tlb_pkg::TIME_MAX) now_r <= now_r + 1'b1;
      end
    end
  end

  `TLB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r[0] <= CW'(tlb_pkg::QUEUE_DEPTH), "queue count overflow")
  `TLB_ASSERT_IMP(a_walk_bound, 1'b1, n_r <= (NW+1)'(tlb_pkg::NODES), "walk past last node")
  `TLB_ASSERT_NXT(a_time_sat, cmd.mig_do && now_r == tlb_pkg::TIME_MAX,
    now_r == tlb_pkg::TIME_MAX, "time wrapped")
endmodule

/* hw/rtl/tlb_ctrl.sv */
// Controller of the threshold load balancer: sequences one item at a time.
// Depends on tlb_pkg and threshold_load_balancer_core_assert.svh.
`include "threshold_load_balancer_core_assert.svh"
module tlb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tlb_pkg::sts_t sts,
  output tlb_pkg::cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_DROP  = 7'b000_0010,
    S_APP   = 7'b000_0100,
    S_SCAN  = 7'b000_1000,
    S_MRD0  = 7'b001_0000,
    S_MRD1  = 7'b010_0000,
    S_MIG   = 7'b100_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1; cmd.drop_start = 1'b1; state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (sts.drop_done) begin
          if (sts.is_tick) begin
            cmd.scan_start = 1'b1; state_nxt = S_SCAN;
          end else state_nxt = S_APP;
        end else cmd.drop_step = 1'b1;
      end
      S_APP: begin
        // hold until the previous word is taken
        if (!ovalid_r || out_ready) begin
          cmd.append = 1'b1; ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_MRD0;
        else cmd.scan_step = 1'b1;
      end
      S_MRD0: begin
        // hold until the previous word is taken
        if (!ovalid_r || out_ready) begin
          cmd.mig_rd = 1'b1; state_nxt = S_MRD1;
        end
      end
      S_MRD1: begin cmd.mig_rd = 1'b1; state_nxt = S_MIG; end
      S_MIG:  begin cmd.mig_do = 1'b1; ovalid_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  `TLB_ASSERT_IMP(a_one_hot, 1'b1, $onehot(state_r), "state not one-hot")
  `TLB_ASSERT_NXT(a_take_leaves_idle, in_valid && in_ready, state_r == S_DROP,
    "accepted word did not start")
  `TLB_ASSERT_IMP(a_no_take_busy, state_r != S_IDLE, !in_ready, "ready while busy")
endmodule

/* hw/rtl/threshold_load_balancer_core.sv */
// Threshold load balancer: one result word per input word, one word at a time.
// Arrival: drop sweep retiring ended jobs on every node, then append. Tick: drop
// sweep, slack scan, tail reads, then migration; sweeps use the single job memory port.
// Words enter only in idle; a waiting result stalls only the append or the tail reads,
// the next word still enters. Reset (rst_n, synchronous): queues empty,
// time zero, threshold 40; job memory is not cleared, only counted entries are used.
module threshold_load_balancer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tlb_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  tlb_pkg::cmd_t cmd;
  tlb_pkg::sts_t sts;
  logic [15:0]   threshold_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) threshold_r <= tlb_pkg::THRESHOLD_RESET;
    else if (cfg_valid) threshold_r <= cfg_data;
  end

  tlb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  tlb_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_word(in_data), .threshold(threshold_r), .res(out_data)
  );
endmodule

/* bench/tb_top.sv */
// Self-checking bench for threshold_load_balancer_core: a scoreboard class mirrors
// the per-node job queues and predicts each result word. Depends on tlb_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class tlb_scoreboard;
    logic [15:0]        threshold;
    logic [31:0]        now;
    tlb_pkg::entry_t    jobs [tlb_pkg::NODES][tlb_pkg::QUEUE_DEPTH];
    int                 head [tlb_pkg::NODES];
    int                 count [tlb_pkg::NODES];
    logic [31:0]        last_end [tlb_pkg::NODES];
    bit                 used [tlb_pkg::NODES];
    tlb_pkg::out_word_t due [$];
    int                 errors;

    function void clear();
      threshold = tlb_pkg::THRESHOLD_RESET;
      now = '0;
      errors = 0;
      for (int n = 0; n < tlb_pkg::NODES; n++) begin
        head[n] = 0;
        count[n] = 0;
        last_end[n] = '0;
        used[n] = 0;
      end
    endfunction

    function logic [31:0] job_end(tlb_pkg::entry_t e);
      logic [32:0] s;
      s = e.start + e.burst;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function int pos(int n, int k);
      return (head[n] + k) % tlb_pkg::QUEUE_DEPTH;
    endfunction

    function logic [31:0] enqueue(int n, logic [15:0] id, logic [15:0] burst);
      tlb_pkg::entry_t e;
      e.id = id;
      e.burst = burst;
      e.start = (used[n] && last_end[n] > now) ? last_end[n] : now;
      jobs[n][pos(n, count[n])] = e;
      count[n]++;
      last_end[n] = job_end(e);
      used[n] = 1;
      return e.start;
    endfunction

    function longint slack(int n);
      longint work;
      work = 0;
      for (int k = 0; k < count[n]; k++) begin
        if (k == 0) work += longint'(job_end(jobs[n][pos(n, 0)])) - longint'(now);
        else work += longint'(jobs[n][pos(n, k)].burst);
      end
      return longint'(threshold) - work;
    endfunction

    function void note(tlb_pkg::in_word_t w);
      tlb_pkg::out_word_t r;
      longint             s, best_max, best_min;
      int                 low, high;
      tlb_pkg::entry_t    e;
      r = '0;
      // retire jobs whose end has passed
      for (int n = 0; n < tlb_pkg::NODES; n++)
        while (count[n] > 0 && job_end(jobs[n][head[n]]) < now) begin
          head[n] = (head[n] + 1) % tlb_pkg::QUEUE_DEPTH;
          count[n]--;
        end
      if (w.mode == tlb_pkg::MODE_ARRIVAL) begin
        if (count[w.node] < tlb_pkg::QUEUE_DEPTH) begin
          r.accepted = 1'b1;
          r.job_start = enqueue(w.node, w.job_id, w.burst_len);
        end
      end else begin
        best_max = 0;
        best_min = 2147483647;
        low = 0;
        high = 0;
        for (int n = 0; n < tlb_pkg::NODES; n++) begin
          s = slack(n);
          if (s > best_max) begin
            best_max = s;
            low = n;
          end
          if (count[n] != 1 && s < best_min) begin
            best_min = s;
            high = n;
          end
        end
        if (count[high] >= 2 && high != low && count[low] < tlb_pkg::QUEUE_DEPTH) begin
          e = jobs[high][pos(high, count[high] - 1)];
          count[high]--;
          last_end[high] = job_end(jobs[high][pos(high, count[high] - 1)]);
          r.job_start = enqueue(low, e.id, e.burst);
          r.migrated = 1'b1;
          r.moved_job_id = e.id;
          r.from_node = high[2:0];
          r.to_node = low[2:0];
        end
        if (now != 32'hFFFF_FFFF) now++;
      end
      due.insert(due.size(), r);
    endfunction

    function void check(tlb_pkg::out_word_t got);
      tlb_pkg::out_word_t exp_w;
      if (due.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_w = due.pop_front();
      if (got.accepted !== exp_w.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $time, exp_w.accepted, got.accepted);
        errors++;
      end
      if (got.job_start !== exp_w.job_start) begin
        $display("%0t: job_start exp %0d got %0d", $time, exp_w.job_start, got.job_start);
        errors++;
      end
      if (got.migrated !== exp_w.migrated) begin
        $display("%0t: migrated exp %0d got %0d", $time, exp_w.migrated, got.migrated);
        errors++;
      end
      if (got.moved_job_id !== exp_w.moved_job_id) begin
        $display("%0t: moved_job_id exp %0d got %0d", $time, exp_w.moved_job_id,
                 got.moved_job_id);
        errors++;
      end
      if (got.from_node !== exp_w.from_node) begin
        $display("%0t: from_node exp %0d got %0d", $time, exp_w.from_node, got.from_node);
        errors++;
      end
      if (got.to_node !== exp_w.to_node) begin
        $display("%0t: to_node exp %0d got %0d", $time, exp_w.to_node, got.to_node);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid, in_ready;
  tlb_pkg::in_word_t  in_data;
  logic               out_valid, out_ready;
  tlb_pkg::out_word_t out_data;
  logic               cfg_valid, cfg_ready;
  logic [15:0]        cfg_data;

  tlb_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;

  threshold_load_balancer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && in_valid && in_ready) sb.note(in_data);
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  task automatic send_word(tlb_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.threshold = v;
  endtask

  // hold until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic tlb_pkg::in_word_t make_word(bit tick, logic [15:0] burst,
                                                  logic [2:0] n);
    tlb_pkg::in_word_t w;
    w.mode = tick ? tlb_pkg::MODE_TICK : tlb_pkg::MODE_ARRIVAL;
    w.job_id = 16'($urandom);
    w.burst_len = burst;
    w.node = n;
    return w;
  endfunction

  function automatic logic [15:0] pick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 16'($urandom);
    if (r < 4) return 16'd0;
    return 16'($urandom_range(1, 12));
  endfunction

  task automatic random_run(int items);
    for (int i = 0; i < items; i++)
      send_word(make_word($urandom_range(99) < 40, pick_burst(), 3'($urandom_range(7))));
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill one node past full, zero and extreme bursts, ticks on
    // an empty and a crowded system, every node bit
    send_word(make_word(1, 16'd0, 3'd0));
    send_word(make_word(0, 16'd0, 3'd2));
    for (int i = 0; i < 9; i++)
      send_word(make_word(0, (i == 4) ? 16'hFFFF : 16'(3 + i), 3'd5));
    send_word(make_word(0, 16'd1, 3'd7));
    send_word(make_word(0, 16'h8000, 3'd7));
    for (int i = 0; i < 8; i++) send_word(make_word(1, 16'hFFFF, 3'(i)));
    drain();

    write_threshold(16'hFFFF);
    send_idle_pct = 29;
    recv_stall_pct = 82;
    random_run(480);
    drain();

    write_threshold(16'd0);
    send_idle_pct = 82;
    recv_stall_pct = 29;
    random_run(480);
    drain();

    write_threshold(16'($urandom_range(5, 60)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_run(480);
    drain();

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("[threshold_load_balancer_core] OK");
    end else begin
      $display("[threshold_load_balancer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[threshold_load_balancer_core] ERROR");
    $finish;
  end
endmodule
